FILE: hdl/scr_pkg.sv
package scr_pkg;

  localparam int unsigned SPILL_WORD_LIMIT = 1048576;
  localparam int unsigned SW_W = $clog2(SPILL_WORD_LIMIT + 2);
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_AW = $clog2(FIFO_DEPTH);
  localparam int unsigned MAX_RES = 3;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [31:0] ID_TERM = 32'd9999;
  localparam logic [31:0] ID_AUX = 32'd1000;
  localparam logic [31:0] TERM_LEN = 32'd2;

  localparam logic [1:0] CFG_MAX_CHUNKS = 2'd0;
  localparam logic [1:0] CFG_MAX_RECORD = 2'd1;
  localparam logic [1:0] CFG_MAX_MODULE = 2'd2;

  localparam logic [7:0] RST_MAX_CHUNKS = 8'd200;
  localparam logic [17:0] RST_MAX_RECORD = 18'd131072;
  localparam logic [7:0] RST_MAX_MODULE = 8'd14;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    VERD_GOOD    = 2'd0,
    VERD_MISSING = 2'd1,
    VERD_RECORD  = 2'd2,
    VERD_RESTART = 2'd3
  } verd_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] word;
    verd_t       verd;
    logic [31:0] good;
    logic [31:0] bad;
    logic        last;
  } res_t;

  typedef struct packed {
    logic        we;
    logic [1:0]  index;
    logic [17:0] data;
  } cfg_wr_t;

endpackage

FILE: hdl/spill_chunk_reassembler.sv
// Spill chunk reassembler.
// Input channel: in_word / in_buffer_end with in_valid and in_stall; a word
// is taken at a clock edge with in_valid high and in_stall low.
// Output channel: zero to three results per word handed over, with out_valid and
// out_stall; payload words of the current spill stream out as they pass,
// and a verdict result closes each spill (good, chunks missing, record
// check failed, restarted). out_run_last flags the final result of a word.
// Configuration: cfg_valid / cfg_ready (always ready), cfg_index selects
// max_chunks (0), max_record_words (1) or max_module_id (2).
// Throughput: one word per cycle while in_stall is low; a word yields up
// to three results, and the output drains one result per cycle while
// out_stall is low, through an 8-entry result queue, which sets the rate
// when words produce more than one result.
// in_stall rises while the queue holds more than five results, including
// while the receiver holds out_stall. Reset clears the parser, counters and
// queue and loads the default limits; the block starts seeking a spill end.
module spill_chunk_reassembler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_word,
  input  logic        in_buffer_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_result_kind,
  output logic [31:0] out_word,
  output logic [1:0]  out_verdict,
  output logic [31:0] out_good_spills,
  output logic [31:0] out_bad_spills,
  output logic        out_run_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [17:0] cfg_data
);
  import scr_pkg::*;

  logic    in_fire;
  logic    room;
  logic    not_empty;
  logic [1:0] push_n;
  res_t    push_res [MAX_RES];
  res_t    head;
  cfg_wr_t cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr.we = cfg_valid;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data = cfg_data;

  assign in_stall = !room;
  assign in_fire = in_valid && room;

  scr_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_fire      (in_fire),
    .in_word      (in_word),
    .in_buffer_end(in_buffer_end),
    .cfg_wr       (cfg_wr),
    .push_n       (push_n),
    .push_res     (push_res)
  );

  scr_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_n   (push_n),
    .push_res (push_res),
    .pop      (!out_stall),
    .not_empty(not_empty),
    .room     (room),
    .head     (head)
  );

  assign out_valid = not_empty;
  assign out_result_kind = head.kind;
  assign out_word = head.word;
  assign out_verdict = head.verd;
  assign out_good_spills = head.good;
  assign out_bad_spills = head.bad;
  assign out_run_last = head.last;

endmodule

FILE: hdl/scr_core.sv
module scr_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic [31:0]         in_word,
  input  logic                in_buffer_end,
  input  scr_pkg::cfg_wr_t    cfg_wr,
  output logic [1:0]          push_n,
  output scr_pkg::res_t       push_res [scr_pkg::MAX_RES]
);
  import scr_pkg::*;

  typedef enum logic [2:0] {
    PH_LEN, PH_TOT, PH_NUM, PH_PAY, PH_TRAIL, PH_SKIP
  } phase_t;

  typedef struct packed {
    logic [SW_W-1:0] sw;
    logic [17:0]     rem;
    logic            vsn;
    logic            failed;
  } rec_t;

  function automatic rec_t feed(rec_t r, logic [31:0] w, logic [17:0] mrec,
                                logic [7:0] mmod);
    rec_t o;
    logic stop;
    o = r;
    stop = 1'b0;
    if (o.sw <= SW_W'(SPILL_WORD_LIMIT)) o.sw = o.sw + 1'b1;
    if (o.failed) stop = 1'b1;
    if (!stop && o.vsn) begin
      o.vsn = 1'b0;
      if (w > {24'b0, mmod} && w != ID_TERM && w != ID_AUX) begin
        o.failed = 1'b1;
        stop = 1'b1;
      end
    end
    if (!stop && o.rem == '0) begin
      if (w == '0 || w > {14'b0, mrec}) begin
        o.failed = 1'b1;
        stop = 1'b1;
      end else begin
        o.rem = w[17:0];
        o.vsn = 1'b1;
      end
    end
    if (!stop) o.rem = o.rem - 1'b1;
    return o;
  endfunction

  function automatic verd_t rec_verdict(rec_t r);
    if (r.failed || r.vsn || r.rem != '0 || r.sw == '0 ||
        r.sw > SW_W'(SPILL_WORD_LIMIT)) return VERD_RECORD;
    return VERD_GOOD;
  endfunction

  function automatic res_t mk(kind_t k, logic [31:0] w, verd_t v,
                              logic [31:0] g, logic [31:0] b);
    res_t o;
    o.kind = k;
    o.word = w;
    o.verd = v;
    o.good = g;
    o.bad = b;
    o.last = 1'b0;
    return o;
  endfunction

  phase_t      phase_r, phase_nxt;
  logic [29:0] cw_r, cw_nxt;
  logic [29:0] pl_r, pl_nxt;
  logic [31:0] tot_r, tot_nxt;
  logic [31:0] pend_r, pend_nxt;
  logic [31:0] num_r, num_nxt;
  logic [31:0] prev_r, prev_nxt;
  logic [7:0]  cis_r, cis_nxt;
  rec_t        rec_r, rec_nxt;
  logic        seek_r, seek_nxt;
  logic        disc_r, disc_nxt;
  logic        first_r, first_nxt;
  logic [31:0] good_r, good_nxt;
  logic [31:0] bad_r, bad_nxt;
  logic [7:0]  max_chunks_r;
  logic [17:0] max_rec_r;
  logic [7:0]  max_mod_r;

  logic [1:0]  n;
  res_t        res [MAX_RES];
  logic        skip_main;
  verd_t       v;

  always_comb begin
    phase_nxt = phase_r;
    cw_nxt = cw_r;
    pl_nxt = pl_r;
    tot_nxt = tot_r;
    pend_nxt = pend_r;
    num_nxt = num_r;
    prev_nxt = prev_r;
    cis_nxt = cis_r;
    rec_nxt = rec_r;
    seek_nxt = seek_r;
    disc_nxt = disc_r;
    first_nxt = first_r;
    good_nxt = good_r;
    bad_nxt = bad_r;
    n = '0;
    skip_main = 1'b0;
    v = VERD_GOOD;
    for (int i = 0; i < MAX_RES; i++) res[i] = '0;
    if (!disc_r) begin
      unique case (phase_r)
        PH_LEN: begin
          if (in_word == ALL_ONES) begin
            disc_nxt = 1'b1;
          end else begin
            cw_nxt = in_word[31:2];
            phase_nxt = PH_TOT;
          end
        end
        PH_TOT: begin
          pend_nxt = in_word;
          if (seek_r || first_r) tot_nxt = in_word;
          if (first_r && in_word > {24'b0, max_chunks_r}) disc_nxt = 1'b1;
          else phase_nxt = PH_NUM;
        end
        PH_NUM: begin
          num_nxt = in_word;
          if (seek_r) begin
            if (first_r && in_word == '0) begin
              seek_nxt = 1'b0;
            end else begin
              first_nxt = 1'b0;
              skip_main = 1'b1;
              if (cw_r < 30'd3) begin
                disc_nxt = 1'b1;
              end else begin
                pl_nxt = cw_r - 30'd2;
                phase_nxt = PH_SKIP;
              end
            end
          end
          if (!skip_main) begin
            first_nxt = 1'b0;
            if (prev_r != ALL_ONES && in_word != prev_r + 32'd1) begin
              if (prev_r + 32'd2 == tot_nxt && {24'b0, cis_r} == tot_nxt - 32'd1) begin
                res[n] = mk(KIND_PAYLOAD, TERM_LEN, VERD_GOOD, good_nxt, bad_nxt);
                n = n + 1'b1;
                rec_nxt = feed(rec_nxt, TERM_LEN, max_rec_r, max_mod_r);
                res[n] = mk(KIND_PAYLOAD, ID_TERM, VERD_GOOD, good_nxt, bad_nxt);
                n = n + 1'b1;
                rec_nxt = feed(rec_nxt, ID_TERM, max_rec_r, max_mod_r);
                v = rec_verdict(rec_nxt);
                good_nxt = good_nxt + 32'd1;
                res[n] = mk(KIND_VERDICT, '0, v, good_nxt, bad_nxt);
                n = n + 1'b1;
                cis_nxt = '0;
                rec_nxt = '0;
                prev_nxt = ALL_ONES;
              end else if (in_word == '0) begin
                bad_nxt = bad_nxt + 32'd1;
                res[n] = mk(KIND_VERDICT, '0, VERD_RESTART, good_nxt, bad_nxt);
                n = n + 1'b1;
                cis_nxt = '0;
                rec_nxt = '0;
                prev_nxt = ALL_ONES;
              end
            end
            tot_nxt = pend_r;
            if (pend_r > {24'b0, max_chunks_r} || in_word > pend_r - 32'd1) begin
              disc_nxt = 1'b1;
            end else begin
              prev_nxt = in_word;
              if (cis_nxt < 8'd255) cis_nxt = cis_nxt + 8'd1;
              if (cw_r < 30'd3) begin
                disc_nxt = 1'b1;
              end else begin
                pl_nxt = cw_r - 30'd3;
                phase_nxt = (pl_nxt != '0) ? PH_PAY : PH_TRAIL;
              end
            end
          end
        end
        PH_SKIP: begin
          pl_nxt = pl_r - 30'd1;
          if (pl_nxt == '0) begin
            if (cw_r == 30'd5) seek_nxt = 1'b0;
            phase_nxt = PH_LEN;
          end
        end
        PH_PAY: begin
          res[n] = mk(KIND_PAYLOAD, in_word, VERD_GOOD, good_r, bad_r);
          n = n + 1'b1;
          rec_nxt = feed(rec_r, in_word, max_rec_r, max_mod_r);
          pl_nxt = pl_r - 30'd1;
          if (pl_nxt == '0) phase_nxt = PH_TRAIL;
        end
        PH_TRAIL: begin
          phase_nxt = PH_LEN;
          if (cw_r == 30'd5 && num_r == tot_r - 32'd1) begin
            if ({24'b0, cis_r} != tot_r) begin
              bad_nxt = bad_r + 32'd1;
              res[n] = mk(KIND_VERDICT, '0, VERD_MISSING, good_r, bad_nxt);
              n = n + 1'b1;
            end else begin
              good_nxt = good_r + 32'd1;
              res[n] = mk(KIND_VERDICT, '0, rec_verdict(rec_r), good_nxt, bad_r);
              n = n + 1'b1;
            end
            cis_nxt = '0;
            rec_nxt = '0;
            prev_nxt = ALL_ONES;
          end
        end
        default: phase_nxt = PH_LEN;
      endcase
    end
    if (in_buffer_end) begin
      first_nxt = 1'b1;
      disc_nxt = 1'b0;
      phase_nxt = PH_LEN;
    end
    if (n != '0) res[n - 2'd1].last = 1'b1;
  end

  assign push_n = in_fire ? n : 2'd0;
  assign push_res = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEN;
      cw_r <= '0;
      pl_r <= '0;
      tot_r <= ALL_ONES;
      pend_r <= '0;
      num_r <= '0;
      prev_r <= ALL_ONES;
      cis_r <= '0;
      rec_r <= '0;
      seek_r <= 1'b1;
      disc_r <= 1'b0;
      first_r <= 1'b1;
      good_r <= '0;
      bad_r <= '0;
      max_chunks_r <= RST_MAX_CHUNKS;
      max_rec_r <= RST_MAX_RECORD;
      max_mod_r <= RST_MAX_MODULE;
    end else begin
      if (in_fire) begin
        phase_r <= phase_nxt;
        cw_r <= cw_nxt;
        pl_r <= pl_nxt;
        tot_r <= tot_nxt;
        pend_r <= pend_nxt;
        num_r <= num_nxt;
        prev_r <= prev_nxt;
        cis_r <= cis_nxt;
        rec_r <= rec_nxt;
        seek_r <= seek_nxt;
        disc_r <= disc_nxt;
        first_r <= first_nxt;
        good_r <= good_nxt;
        bad_r <= bad_nxt;
      end
      if (cfg_wr.we) begin
        unique case (cfg_wr.index)
          CFG_MAX_CHUNKS: max_chunks_r <= cfg_wr.data[7:0];
          CFG_MAX_RECORD: max_rec_r <= cfg_wr.data;
          CFG_MAX_MODULE: max_mod_r <= cfg_wr.data[7:0];
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: hdl/scr_fifo.sv
module scr_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [1:0]    push_n,
  input  scr_pkg::res_t push_res [scr_pkg::MAX_RES],
  input  logic          pop,
  output logic          not_empty,
  output logic          room,
  output scr_pkg::res_t head
);
  import scr_pkg::*;

  res_t                 mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   rd_r, rd_nxt;
  logic [FIFO_AW-1:0]   wr_r, wr_nxt;
  logic [FIFO_AW:0]     cnt_r, cnt_nxt;
  logic                 do_pop;

  assign not_empty = cnt_r != '0;
  assign room = cnt_r <= (FIFO_AW + 1)'(FIFO_DEPTH - MAX_RES);
  assign head = mem_r[rd_r];
  assign do_pop = pop && not_empty;

  always_comb begin
    rd_nxt = rd_r + FIFO_AW'(do_pop);
    wr_nxt = wr_r + FIFO_AW'(push_n);
    cnt_nxt = cnt_r + (FIFO_AW + 1)'(push_n) - (FIFO_AW + 1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (FIFO_AW'(i) < FIFO_AW'(push_n)) mem_r[wr_r + FIFO_AW'(i)] <= push_res[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= '0;
      wr_r <= '0;
      cnt_r <= '0;
    end else begin
      rd_r <= rd_nxt;
      wr_r <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
